// ===== sv/hpd_pkg.sv =====
package hpd_pkg;

  // Fixed field widths of the result and configuration words.
  localparam int ORDER_W    = 10;
  localparam int NM_W       = 4;
  localparam int FD_W       = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic [NM_W-1:0] NM_RESET = 4'd5;
  localparam logic [FD_W-1:0] FD_RESET = 16'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_MULT = 4'd0,
    CFG_FUND_DIV   = 4'd1
  } cfg_reg_t;

  // Result buffer holds one entry per finished spectrum.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Control flags that travel with a bin down the front pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctl_t;

endpackage

// ===== sv/harmonic_peak_detector.sv =====
// Harmonic peak detector. Spectrum bins enter one word per cycle from DC upward,
// with in_last_bin on the final bin. Bin 1 is the fundamental; bins 2 and up form
// the noise estimate and the peak search (earliest bin wins a tie). For each
// spectrum of at least two bins the block reports the fundamental, then the peak
// when its power beats noise_multiplier times the average noise power and the
// fundamental power divided by fundamental_divisor; out_last_result marks the
// final word of a spectrum. A new bin is taken every cycle while in_ready is high.
// The first result word appears once the last bin has passed through the input,
// square, accumulate, cross-product and result-buffer registers. The buffer holds
// eight spectra of results; in_ready drops only when that buffer, counting last
// bins still in the pipeline, is full because out_ready is held low. A spectrum
// with an accepted peak gives two output words. The configuration
// port is always ready and must be written only while the block is idle.
module harmonic_peak_detector #(
  parameter int MAX_BINS = 1024,
  parameter int BIN_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [BIN_BITS-1:0]          in_bin_real,
  input  logic signed [BIN_BITS-1:0]          in_bin_imag,
  input  logic                                in_last_bin,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hpd_pkg::ORDER_W-1:0]         out_harmonic_order,
  output logic signed [BIN_BITS-1:0]          out_phasor_real,
  output logic signed [BIN_BITS-1:0]          out_phasor_imag,
  output logic [2*BIN_BITS-1:0]               out_power_sq,
  output logic                                out_last_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hpd_pkg::*;

  localparam int PW = 2 * BIN_BITS;
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int SW = PW + CW - 1;
  localparam int RESV_W = FIFO_CW + 1;

  logic [NM_W-1:0] noise_mult_r;
  logic [FD_W-1:0] fund_div_r;

  logic                       in_take;
  beat_ctl_t                  in_ctl;
  beat_ctl_t                  sq_ctl;
  logic signed [BIN_BITS-1:0] sq_re;
  logic signed [BIN_BITS-1:0] sq_im;
  logic [PW-1:0]              sq_pw;

  logic                       snap_valid;
  logic signed [BIN_BITS-1:0] snap_fund_re;
  logic signed [BIN_BITS-1:0] snap_fund_im;
  logic [PW-1:0]              snap_fund_pw;
  logic                       snap_seen;
  logic [CW-1:0]              snap_peak_idx;
  logic signed [BIN_BITS-1:0] snap_peak_re;
  logic signed [BIN_BITS-1:0] snap_peak_im;
  logic [PW-1:0]              snap_peak_pw;
  logic [SW-1:0]              snap_sum;
  logic [CW-1:0]              snap_cnt;

  logic                       res_valid;
  logic                       res_accept;
  logic signed [BIN_BITS-1:0] res_fund_re;
  logic signed [BIN_BITS-1:0] res_fund_im;
  logic [PW-1:0]              res_fund_pw;
  logic [ORDER_W-1:0]         res_peak_order;
  logic signed [BIN_BITS-1:0] res_peak_re;
  logic signed [BIN_BITS-1:0] res_peak_im;
  logic [PW-1:0]              res_peak_pw;

  logic [FIFO_CW-1:0]         fifo_fill;
  logic [RESV_W-1:0]          demand;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_mult_r <= NM_RESET;
      fund_div_r   <= FD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NOISE_MULT: noise_mult_r <= cfg_data[NM_W-1:0];
        CFG_FUND_DIV:   fund_div_r   <= cfg_data[FD_W-1:0];
        default: ;
      endcase
    end
  end

  // Every last bin in flight holds a buffer slot, so the pipeline never stalls.
  assign demand = RESV_W'(fifo_fill) + RESV_W'(in_ctl.last) + RESV_W'(sq_ctl.last)
                + RESV_W'(snap_valid) + RESV_W'(res_valid);
  assign in_ready = demand < RESV_W'(FIFO_DEPTH);
  assign in_take  = in_valid && in_ready;

  hpd_power #(
    .BIN_BITS (BIN_BITS)
  ) u_power (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .bin_re   (in_bin_real),
    .bin_im   (in_bin_imag),
    .bin_last (in_last_bin),
    .in_ctl   (in_ctl),
    .sq_ctl   (sq_ctl),
    .sq_re    (sq_re),
    .sq_im    (sq_im),
    .sq_pw    (sq_pw)
  );

  hpd_accum #(
    .BIN_BITS (BIN_BITS),
    .MAX_BINS (MAX_BINS)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .sq_ctl        (sq_ctl),
    .sq_re         (sq_re),
    .sq_im         (sq_im),
    .sq_pw         (sq_pw),
    .snap_valid    (snap_valid),
    .snap_fund_re  (snap_fund_re),
    .snap_fund_im  (snap_fund_im),
    .snap_fund_pw  (snap_fund_pw),
    .snap_seen     (snap_seen),
    .snap_peak_idx (snap_peak_idx),
    .snap_peak_re  (snap_peak_re),
    .snap_peak_im  (snap_peak_im),
    .snap_peak_pw  (snap_peak_pw),
    .snap_sum      (snap_sum),
    .snap_cnt      (snap_cnt)
  );

  hpd_decide #(
    .BIN_BITS (BIN_BITS),
    .MAX_BINS (MAX_BINS)
  ) u_decide (
    .clk            (clk),
    .rst_n          (rst_n),
    .noise_mult     (noise_mult_r),
    .fund_div       (fund_div_r),
    .snap_valid     (snap_valid),
    .snap_fund_re   (snap_fund_re),
    .snap_fund_im   (snap_fund_im),
    .snap_fund_pw   (snap_fund_pw),
    .snap_seen      (snap_seen),
    .snap_peak_idx  (snap_peak_idx),
    .snap_peak_re   (snap_peak_re),
    .snap_peak_im   (snap_peak_im),
    .snap_peak_pw   (snap_peak_pw),
    .snap_sum       (snap_sum),
    .snap_cnt       (snap_cnt),
    .res_valid      (res_valid),
    .res_accept     (res_accept),
    .res_fund_re    (res_fund_re),
    .res_fund_im    (res_fund_im),
    .res_fund_pw    (res_fund_pw),
    .res_peak_order (res_peak_order),
    .res_peak_re    (res_peak_re),
    .res_peak_im    (res_peak_im),
    .res_peak_pw    (res_peak_pw)
  );

  hpd_result_fifo #(
    .BIN_BITS (BIN_BITS)
  ) u_result_fifo (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (res_valid),
    .push_accept     (res_accept),
    .push_fund_re    (res_fund_re),
    .push_fund_im    (res_fund_im),
    .push_fund_pw    (res_fund_pw),
    .push_peak_order (res_peak_order),
    .push_peak_re    (res_peak_re),
    .push_peak_im    (res_peak_im),
    .push_peak_pw    (res_peak_pw),
    .fill            (fifo_fill),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_order       (out_harmonic_order),
    .out_re          (out_phasor_real),
    .out_im          (out_phasor_imag),
    .out_pw          (out_power_sq),
    .out_last        (out_last_result)
  );

endmodule

// ===== sv/hpd_power.sv =====
module hpd_power #(
  parameter int BIN_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic signed [BIN_BITS-1:0]  bin_re,
  input  logic signed [BIN_BITS-1:0]  bin_im,
  input  logic                        bin_last,
  output hpd_pkg::beat_ctl_t          in_ctl,
  output hpd_pkg::beat_ctl_t          sq_ctl,
  output logic signed [BIN_BITS-1:0]  sq_re,
  output logic signed [BIN_BITS-1:0]  sq_im,
  output logic [2*BIN_BITS-1:0]       sq_pw
);
  import hpd_pkg::*;

  localparam int PW = 2 * BIN_BITS;

  beat_ctl_t                  in_ctl_r;
  logic signed [BIN_BITS-1:0] in_re_r;
  logic signed [BIN_BITS-1:0] in_im_r;
  beat_ctl_t                  sq_ctl_r;
  logic signed [BIN_BITS-1:0] sq_re_r;
  logic signed [BIN_BITS-1:0] sq_im_r;
  logic [PW-1:0]              sq_pw_r;
  logic signed [PW-1:0]       re_sq;
  logic signed [PW-1:0]       im_sq;
  logic [PW-1:0]              pw_nxt;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
    end else begin
      in_ctl_r.valid <= take;
      in_ctl_r.last  <= take & bin_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_re_r <= bin_re;
      in_im_r <= bin_im;
    end
  end

  // Squared magnitude; each square is nonnegative and their sum is at most 2^(PW-1).
  assign re_sq  = PW'(in_re_r) * PW'(in_re_r);
  assign im_sq  = PW'(in_im_r) * PW'(in_im_r);
  assign pw_nxt = $unsigned(re_sq) + $unsigned(im_sq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl_r <= '0;
    end else begin
      sq_ctl_r <= in_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl_r.valid) begin
      sq_re_r <= in_re_r;
      sq_im_r <= in_im_r;
      sq_pw_r <= pw_nxt;
    end
  end

  assign in_ctl = in_ctl_r;
  assign sq_ctl = sq_ctl_r;
  assign sq_re  = sq_re_r;
  assign sq_im  = sq_im_r;
  assign sq_pw  = sq_pw_r;

endmodule

// ===== sv/hpd_accum.sv =====
module hpd_accum #(
  parameter int BIN_BITS = 24,
  parameter int MAX_BINS = 1024,
  localparam int PW = 2 * BIN_BITS,
  localparam int CW = $clog2(MAX_BINS + 1),
  localparam int SW = PW + CW - 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hpd_pkg::beat_ctl_t          sq_ctl,
  input  logic signed [BIN_BITS-1:0]  sq_re,
  input  logic signed [BIN_BITS-1:0]  sq_im,
  input  logic [PW-1:0]               sq_pw,
  output logic                        snap_valid,
  output logic signed [BIN_BITS-1:0]  snap_fund_re,
  output logic signed [BIN_BITS-1:0]  snap_fund_im,
  output logic [PW-1:0]               snap_fund_pw,
  output logic                        snap_seen,
  output logic [CW-1:0]               snap_peak_idx,
  output logic signed [BIN_BITS-1:0]  snap_peak_re,
  output logic signed [BIN_BITS-1:0]  snap_peak_im,
  output logic [PW-1:0]               snap_peak_pw,
  output logic [SW-1:0]               snap_sum,
  output logic [CW-1:0]               snap_cnt
);
  import hpd_pkg::*;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BINS);

  // Spectrum state.
  logic [CW-1:0]              cnt_r;
  logic                       seen_r;
  logic [SW-1:0]              sum_r;
  logic signed [BIN_BITS-1:0] fund_re_r;
  logic signed [BIN_BITS-1:0] fund_im_r;
  logic [PW-1:0]              fund_pw_r;
  logic [CW-1:0]              pk_idx_r;
  logic signed [BIN_BITS-1:0] pk_re_r;
  logic signed [BIN_BITS-1:0] pk_im_r;
  logic [PW-1:0]              pk_pw_r;

  // Snapshot register handed to the decision stage.
  logic                       snap_valid_r;
  logic signed [BIN_BITS-1:0] snap_fund_re_r;
  logic signed [BIN_BITS-1:0] snap_fund_im_r;
  logic [PW-1:0]              snap_fund_pw_r;
  logic                       snap_seen_r;
  logic [CW-1:0]              snap_peak_idx_r;
  logic signed [BIN_BITS-1:0] snap_peak_re_r;
  logic signed [BIN_BITS-1:0] snap_peak_im_r;
  logic [PW-1:0]              snap_peak_pw_r;
  logic [SW-1:0]              snap_sum_r;
  logic [CW-1:0]              snap_cnt_r;

  logic                       in_range;
  logic                       is_fund;
  logic                       is_noise;
  logic                       take_peak;
  logic [CW-1:0]              cnt_nxt;
  logic [SW-1:0]              sum_nxt;
  logic                       seen_nxt;
  logic signed [BIN_BITS-1:0] fund_re_nxt;
  logic signed [BIN_BITS-1:0] fund_im_nxt;
  logic [PW-1:0]              fund_pw_nxt;
  logic [CW-1:0]              pk_idx_nxt;
  logic signed [BIN_BITS-1:0] pk_re_nxt;
  logic signed [BIN_BITS-1:0] pk_im_nxt;
  logic [PW-1:0]              pk_pw_nxt;

  // Bin 1 is the fundamental; later bins feed the noise sum and the peak search.
  // Bins past the maximum count are dropped, but their last flag still ends the spectrum.
  always_comb begin
    in_range  = cnt_r < MAX_CNT;
    is_fund   = in_range && (cnt_r == CW'(1));
    is_noise  = in_range && (cnt_r >= CW'(2));
    take_peak = is_noise && (!seen_r || (sq_pw > pk_pw_r));

    cnt_nxt     = in_range ? cnt_r + CW'(1) : cnt_r;
    sum_nxt     = is_noise ? sum_r + SW'(sq_pw) : sum_r;
    seen_nxt    = seen_r | is_noise;
    fund_re_nxt = is_fund ? sq_re : fund_re_r;
    fund_im_nxt = is_fund ? sq_im : fund_im_r;
    fund_pw_nxt = is_fund ? sq_pw : fund_pw_r;
    pk_idx_nxt  = take_peak ? cnt_r : pk_idx_r;
    pk_re_nxt   = take_peak ? sq_re : pk_re_r;
    pk_im_nxt   = take_peak ? sq_im : pk_im_r;
    pk_pw_nxt   = take_peak ? sq_pw : pk_pw_r;
  end

  // Counter, peak flag and noise sum restart after the last bin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      seen_r <= 1'b0;
      sum_r  <= '0;
    end else if (sq_ctl.valid) begin
      if (sq_ctl.last) begin
        cnt_r  <= '0;
        seen_r <= 1'b0;
        sum_r  <= '0;
      end else begin
        cnt_r  <= cnt_nxt;
        seen_r <= seen_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  // Fundamental and peak values are only read once written in the same spectrum.
  always_ff @(posedge clk) begin
    if (sq_ctl.valid) begin
      fund_re_r <= fund_re_nxt;
      fund_im_r <= fund_im_nxt;
      fund_pw_r <= fund_pw_nxt;
      pk_idx_r  <= pk_idx_nxt;
      pk_re_r   <= pk_re_nxt;
      pk_im_r   <= pk_im_nxt;
      pk_pw_r   <= pk_pw_nxt;
    end
  end

  // A spectrum of two bins or more leaves a snapshot for the decision stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= sq_ctl.valid && sq_ctl.last && (cnt_nxt >= CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ctl.valid && sq_ctl.last) begin
      snap_fund_re_r  <= fund_re_nxt;
      snap_fund_im_r  <= fund_im_nxt;
      snap_fund_pw_r  <= fund_pw_nxt;
      snap_seen_r     <= seen_nxt;
      snap_peak_idx_r <= pk_idx_nxt;
      snap_peak_re_r  <= pk_re_nxt;
      snap_peak_im_r  <= pk_im_nxt;
      snap_peak_pw_r  <= pk_pw_nxt;
      snap_sum_r      <= sum_nxt;
      snap_cnt_r      <= cnt_nxt;
    end
  end

  assign snap_valid    = snap_valid_r;
  assign snap_fund_re  = snap_fund_re_r;
  assign snap_fund_im  = snap_fund_im_r;
  assign snap_fund_pw  = snap_fund_pw_r;
  assign snap_seen     = snap_seen_r;
  assign snap_peak_idx = snap_peak_idx_r;
  assign snap_peak_re  = snap_peak_re_r;
  assign snap_peak_im  = snap_peak_im_r;
  assign snap_peak_pw  = snap_peak_pw_r;
  assign snap_sum      = snap_sum_r;
  assign snap_cnt      = snap_cnt_r;

endmodule

// ===== sv/hpd_decide.sv =====
module hpd_decide #(
  parameter int BIN_BITS = 24,
  parameter int MAX_BINS = 1024,
  localparam int PW = 2 * BIN_BITS,
  localparam int CW = $clog2(MAX_BINS + 1),
  localparam int SW = PW + CW - 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [hpd_pkg::NM_W-1:0]          noise_mult,
  input  logic [hpd_pkg::FD_W-1:0]          fund_div,
  input  logic                              snap_valid,
  input  logic signed [BIN_BITS-1:0]        snap_fund_re,
  input  logic signed [BIN_BITS-1:0]        snap_fund_im,
  input  logic [PW-1:0]                     snap_fund_pw,
  input  logic                              snap_seen,
  input  logic [CW-1:0]                     snap_peak_idx,
  input  logic signed [BIN_BITS-1:0]        snap_peak_re,
  input  logic signed [BIN_BITS-1:0]        snap_peak_im,
  input  logic [PW-1:0]                     snap_peak_pw,
  input  logic [SW-1:0]                     snap_sum,
  input  logic [CW-1:0]                     snap_cnt,
  output logic                              res_valid,
  output logic                              res_accept,
  output logic signed [BIN_BITS-1:0]        res_fund_re,
  output logic signed [BIN_BITS-1:0]        res_fund_im,
  output logic [PW-1:0]                     res_fund_pw,
  output logic [hpd_pkg::ORDER_W-1:0]       res_peak_order,
  output logic signed [BIN_BITS-1:0]        res_peak_re,
  output logic signed [BIN_BITS-1:0]        res_peak_im,
  output logic [PW-1:0]                     res_peak_pw
);
  import hpd_pkg::*;

  localparam int LW = PW + CW;
  localparam int RW = SW + NM_W;
  localparam int FW = PW + FD_W;

  logic                       valid_r;
  logic                       seen_r;
  logic [LW-1:0]              lhs_r;
  logic [RW-1:0]              rhs_r;
  logic [FW-1:0]              fprod_r;
  logic signed [BIN_BITS-1:0] fund_re_r;
  logic signed [BIN_BITS-1:0] fund_im_r;
  logic [PW-1:0]              fund_pw_r;
  logic [ORDER_W-1:0]         pk_order_r;
  logic signed [BIN_BITS-1:0] pk_re_r;
  logic signed [BIN_BITS-1:0] pk_im_r;
  logic [PW-1:0]              pk_pw_r;
  logic [CW-1:0]              noise_cnt;

  // Noise bins are all bins from index 2 on; only read when a peak exists.
  assign noise_cnt = snap_cnt - CW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= snap_valid;
    end
  end

  // Cross products stand in for the two divisions.
  always_ff @(posedge clk) begin
    if (snap_valid) begin
      seen_r     <= snap_seen;
      lhs_r      <= LW'(snap_peak_pw) * LW'(noise_cnt);
      rhs_r      <= RW'(snap_sum) * RW'(noise_mult);
      fprod_r    <= FW'(snap_peak_pw) * FW'(fund_div);
      fund_re_r  <= snap_fund_re;
      fund_im_r  <= snap_fund_im;
      fund_pw_r  <= snap_fund_pw;
      pk_order_r <= ORDER_W'(snap_peak_idx);
      pk_re_r    <= snap_peak_re;
      pk_im_r    <= snap_peak_im;
      pk_pw_r    <= snap_peak_pw;
    end
  end

  // The peak must beat both the scaled noise average and the scaled-down fundamental.
  assign res_accept = seen_r && (RW'(lhs_r) > rhs_r) && (fprod_r > FW'(fund_pw_r));

  assign res_valid      = valid_r;
  assign res_fund_re    = fund_re_r;
  assign res_fund_im    = fund_im_r;
  assign res_fund_pw    = fund_pw_r;
  assign res_peak_order = pk_order_r;
  assign res_peak_re    = pk_re_r;
  assign res_peak_im    = pk_im_r;
  assign res_peak_pw    = pk_pw_r;

endmodule

// ===== sv/hpd_result_fifo.sv =====
module hpd_result_fifo #(
  parameter int BIN_BITS = 24,
  localparam int PW = 2 * BIN_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic                              push_accept,
  input  logic signed [BIN_BITS-1:0]        push_fund_re,
  input  logic signed [BIN_BITS-1:0]        push_fund_im,
  input  logic [PW-1:0]                     push_fund_pw,
  input  logic [hpd_pkg::ORDER_W-1:0]       push_peak_order,
  input  logic signed [BIN_BITS-1:0]        push_peak_re,
  input  logic signed [BIN_BITS-1:0]        push_peak_im,
  input  logic [PW-1:0]                     push_peak_pw,
  output logic [hpd_pkg::FIFO_CW-1:0]       fill,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hpd_pkg::ORDER_W-1:0]       out_order,
  output logic signed [BIN_BITS-1:0]        out_re,
  output logic signed [BIN_BITS-1:0]        out_im,
  output logic [PW-1:0]                     out_pw,
  output logic                              out_last
);
  import hpd_pkg::*;

  localparam logic [FIFO_CW-1:0] FULL = FIFO_CW'(FIFO_DEPTH);

  // One entry per spectrum: the fundamental and, when accepted, the peak.
  logic                       acc_mem   [FIFO_DEPTH];
  logic signed [BIN_BITS-1:0] fre_mem   [FIFO_DEPTH];
  logic signed [BIN_BITS-1:0] fim_mem   [FIFO_DEPTH];
  logic [PW-1:0]              fpw_mem   [FIFO_DEPTH];
  logic [ORDER_W-1:0]         pord_mem  [FIFO_DEPTH];
  logic signed [BIN_BITS-1:0] pre_mem   [FIFO_DEPTH];
  logic signed [BIN_BITS-1:0] pim_mem   [FIFO_DEPTH];
  logic [PW-1:0]              ppw_mem   [FIFO_DEPTH];

  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               phase_r;
  logic               take;
  logic               pop;
  logic               head_acc;

  always_ff @(posedge clk) begin
    if (push) begin
      acc_mem[wr_ptr_r]  <= push_accept;
      fre_mem[wr_ptr_r]  <= push_fund_re;
      fim_mem[wr_ptr_r]  <= push_fund_im;
      fpw_mem[wr_ptr_r]  <= push_fund_pw;
      pord_mem[wr_ptr_r] <= push_peak_order;
      pre_mem[wr_ptr_r]  <= push_peak_re;
      pim_mem[wr_ptr_r]  <= push_peak_im;
      ppw_mem[wr_ptr_r]  <= push_peak_pw;
    end
  end

  // The head entry gives the fundamental word first, then the peak word if accepted.
  assign head_acc  = acc_mem[rd_ptr_r];
  assign out_valid = cnt_r != '0;
  assign take      = out_valid && out_ready;
  assign pop       = take && (phase_r || !head_acc);

  always_comb begin
    if (phase_r) begin
      out_order = pord_mem[rd_ptr_r];
      out_re    = pre_mem[rd_ptr_r];
      out_im    = pim_mem[rd_ptr_r];
      out_pw    = ppw_mem[rd_ptr_r];
      out_last  = 1'b1;
    end else begin
      out_order = ORDER_W'(1);
      out_re    = fre_mem[rd_ptr_r];
      out_im    = fim_mem[rd_ptr_r];
      out_pw    = fpw_mem[rd_ptr_r];
      out_last  = !head_acc;
    end
  end

  // Pointers, fill count and word phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CW'(1);
      end
      if (take) begin
        phase_r <= !pop;
      end
    end
  end

  assign fill = cnt_r;

  // The entry reservation upstream must keep a slot free for every push.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != FULL))
    else $error("result buffer written while full");

  // The peak word is only shown for a stored entry whose peak was accepted.
  a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (cnt_r != '0) && head_acc)
    else $error("peak word phase without an accepted peak at the head");

  // A push without a pop grows the fill count by exactly one.
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + FIFO_CW'(1)))
    else $error("fill count did not follow a push");

endmodule
